FILE: rtl/sacm_pkg.sv
// Shared types and constants of the set-associative cache model block.
// Used by sacm_ctrl, sacm_datapath and set_assoc_cache_mru_model_unit.
package sacm_pkg;

    localparam int ADDR_FIELD_W = 64;
    localparam int TAG_W        = 62;
    localparam int RECENT_W     = 3;
    localparam int WAY_FIELD_W  = 3;
    localparam int TOTAL_W      = 32;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_BLOCK_BITS  = 2'd1;
    localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

    localparam logic [3:0] SET_BITS_RST    = 4'd4;
    localparam logic [5:0] BLOCK_BITS_RST  = 6'd4;
    localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;

    // Command codes of an input item
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_MODIFY = 1'b1;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic                    command;
        logic [ADDR_FIELD_W-1:0] address;
    } in_item_t;

    typedef struct packed {
        outcome_t               outcome;
        logic [WAY_FIELD_W-1:0] way_used;
        logic [TOTAL_W-1:0]     hit_total;
        logic [TOTAL_W-1:0]     miss_total;
        logic [TOTAL_W-1:0]     eviction_total;
    } result_t;

    typedef struct packed {
        logic [3:0] set_bits;
        logic [5:0] block_bits;
        logic [3:0] ways_in_use;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

endpackage

FILE: rtl/sacm_ctrl.sv
// Controller of the cache model: accepts items and sequences read and write-back.
// Uses sacm_pkg for the state and command types.
module sacm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    output sacm_pkg::ctrl_cmd_t  cmd
);

    sacm_pkg::state_t state_reg;
    sacm_pkg::state_t state_next;
    logic             done_reg;
    logic             accept;

    assign accept = start && (state_reg == sacm_pkg::ST_IDLE);

    always_comb
    begin
        case (state_reg)
            sacm_pkg::ST_IDLE:
            begin
                state_next = accept ? sacm_pkg::ST_LOOKUP : sacm_pkg::ST_IDLE;
            end
            sacm_pkg::ST_LOOKUP:
            begin
                state_next = sacm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sacm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        busy       = 1'b0;
        case (state_reg)
            sacm_pkg::ST_IDLE:
            begin
                cmd.load = accept;
            end
            sacm_pkg::ST_LOOKUP:
            begin
                cmd.commit = 1'b1;
                busy       = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sacm_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.commit;
        end
    end

    assign done = done_reg;

    // A lookup always ends in a return to idle and a result strobe
    a_lookup_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sacm_pkg::ST_LOOKUP) |=> (state_reg == sacm_pkg::ST_IDLE) && done_reg)
        else $error("lookup did not end with a result strobe");

    // Every strobe follows an accepted item, by way of the lookup state and the done register
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(accept, 2))
        else $error("result strobe without an accepted item");

endmodule

FILE: rtl/sacm_datapath.sv
// Datapath of the cache model: set/tag decode, set row memory, way compare,
// replacement choice, saturating totals and result register. Uses sacm_pkg.
module sacm_datapath #(
    parameter int MAX_SET_BITS = 8,
    parameter int WAYS         = 8,
    parameter int ADDR_WIDTH   = 64,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sacm_pkg::ctrl_cmd_t cmd,
    input  sacm_pkg::in_item_t  item,
    input  sacm_pkg::cfg_t      cfg,
    output sacm_pkg::result_t   result
);

    localparam int SETS      = 1 << MAX_SET_BITS;
    localparam int WAY_IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCNT_W    = $clog2(WAYS + 1);
    localparam int TAG_W     = sacm_pkg::TAG_W;
    localparam int RECENT_W  = sacm_pkg::RECENT_W;
    localparam int VALID_LO  = RECENT_W;
    localparam int TAGS_LO   = RECENT_W + WAYS;
    localparam int ROW_W     = RECENT_W + WAYS + WAYS * TAG_W;
    localparam logic [63:0] ADDR_MASK =
        (ADDR_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_WIDTH) - 64'd1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Set row memory: recent way, valid bits and tags of one set
    logic [ROW_W-1:0]        mem [SETS];
    logic [SETS-1:0]         row_init_reg;
    logic [ROW_W-1:0]        row_q;
    logic                    init_q;

    logic [MAX_SET_BITS-1:0] set_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic                    modify_reg;

    logic [COUNT_WIDTH-1:0]  hit_reg;
    logic [COUNT_WIDTH-1:0]  miss_reg;
    logic [COUNT_WIDTH-1:0]  evict_reg;
    logic [COUNT_WIDTH-1:0]  hit_next;
    logic [COUNT_WIDTH-1:0]  miss_next;
    logic [COUNT_WIDTH-1:0]  evict_next;
    sacm_pkg::result_t       result_reg;

    logic [63:0]             addr_m;
    logic [3:0]              sb;
    logic [63:0]             off_shift;
    logic [63:0]             tag_shift;
    logic [6:0]              tag_shamt;
    logic [MAX_SET_BITS-1:0] set_mask;
    logic [MAX_SET_BITS-1:0] set_idx;

    logic [WCNT_W-1:0]       ways;
    logic [WAYS-1:0]         valid_vec;
    logic [WAYS-1:0]         hit_vec;
    logic [WAYS-1:0]         free_vec;
    logic [WAY_IDX_W-1:0]    hit_way;
    logic [WAY_IDX_W-1:0]    free_way;
    logic [WAY_IDX_W-1:0]    chosen;
    logic [RECENT_W-1:0]     recent;
    sacm_pkg::outcome_t      outcome;
    logic [ROW_W-1:0]        row_w;
    logic [COUNT_WIDTH-1:0]  hit_mid;

    // Decode of the offered item, valid in the accept cycle
    always_comb
    begin
        addr_m    = item.address & ADDR_MASK;
        sb        = (cfg.set_bits > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : cfg.set_bits;
        off_shift = addr_m >> cfg.block_bits;
        set_mask  = ~({MAX_SET_BITS{1'b1}} << sb);
        set_idx   = off_shift[MAX_SET_BITS-1:0] & set_mask;
        tag_shamt = 7'(cfg.block_bits) + 7'(sb);
        tag_shift = addr_m >> tag_shamt;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_q      <= mem[set_idx];
            init_q     <= row_init_reg[set_idx];
            set_reg    <= set_idx;
            tag_reg    <= tag_shift[TAG_W-1:0];
            modify_reg <= (item.command == sacm_pkg::CMD_MODIFY);
        end
        if (cmd.commit)
        begin
            mem[set_reg] <= row_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_init_reg <= '0;
        end
        else if (cmd.commit)
        begin
            row_init_reg[set_reg] <= 1'b1;
        end
    end

    // Way compare and replacement choice on the row read at accept
    always_comb
    begin
        if (cfg.ways_in_use == '0)
            ways = WCNT_W'(1);
        else if (5'(cfg.ways_in_use) > 5'(WAYS))
            ways = WCNT_W'(WAYS);
        else
            ways = WCNT_W'(cfg.ways_in_use);

        // A set never written reads as all lines invalid
        valid_vec = init_q ? row_q[VALID_LO +: WAYS] : '0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w]  = (WCNT_W'(w) < ways) && valid_vec[w]
                          && (row_q[TAGS_LO + w*TAG_W +: TAG_W] == tag_reg);
            free_vec[w] = (WCNT_W'(w) < ways) && !valid_vec[w];
        end

        hit_way  = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
                hit_way = WAY_IDX_W'(w);
            if (free_vec[w])
                free_way = WAY_IDX_W'(w);
        end

        recent = row_q[RECENT_W-1:0];
        if (hit_vec != '0)
        begin
            outcome = sacm_pkg::OUT_HIT;
            chosen  = hit_way;
        end
        else if (free_vec != '0)
        begin
            outcome = sacm_pkg::OUT_FILL;
            chosen  = free_way;
        end
        else
        begin
            outcome = sacm_pkg::OUT_EVICT;
            // drop a recorded way that lies beyond the ways now in use
            chosen  = (5'(recent) >= 5'(ways)) ? '0 : WAY_IDX_W'(recent);
        end

        row_w                      = row_q;
        row_w[RECENT_W-1:0]        = RECENT_W'(chosen);
        row_w[VALID_LO +: WAYS]    = valid_vec;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_IDX_W'(w) == chosen)
            begin
                row_w[VALID_LO + w]               = 1'b1;
                row_w[TAGS_LO + w*TAG_W +: TAG_W] = tag_reg;
            end
        end
    end

    // Saturating totals; a modify counts its extra hit first
    always_comb
    begin
        hit_mid    = (modify_reg && hit_reg != CNT_MAX) ? hit_reg + 1'b1 : hit_reg;
        hit_next   = (outcome == sacm_pkg::OUT_HIT && hit_mid != CNT_MAX)
                     ? hit_mid + 1'b1 : hit_mid;
        miss_next  = (outcome != sacm_pkg::OUT_HIT && miss_reg != CNT_MAX)
                     ? miss_reg + 1'b1 : miss_reg;
        evict_next = (outcome == sacm_pkg::OUT_EVICT && evict_reg != CNT_MAX)
                     ? evict_reg + 1'b1 : evict_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= '0;
            miss_reg  <= '0;
            evict_reg <= '0;
        end
        else if (cmd.commit)
        begin
            hit_reg   <= hit_next;
            miss_reg  <= miss_next;
            evict_reg <= evict_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_reg.outcome        <= outcome;
            result_reg.way_used       <= sacm_pkg::WAY_FIELD_W'(chosen);
            result_reg.hit_total      <= sacm_pkg::TOTAL_W'(hit_next);
            result_reg.miss_total     <= sacm_pkg::TOTAL_W'(miss_next);
            result_reg.eviction_total <= sacm_pkg::TOTAL_W'(evict_next);
        end
    end

    assign result = result_reg;

    // Every eviction is also a miss
    a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
        evict_reg <= miss_reg)
        else $error("eviction total above miss total");

    // A hit leaves the miss and eviction totals alone
    a_hit_no_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && outcome == sacm_pkg::OUT_HIT) |=>
            $stable(miss_reg) && $stable(evict_reg))
        else $error("hit changed miss or eviction total");

endmodule

FILE: rtl/set_assoc_cache_mru_model_unit.sv
// Top level of the tag-only set-associative cache model with MRU replacement.
// Holds the configuration registers; uses sacm_pkg, sacm_ctrl and sacm_datapath.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------
//  input     | start high, busy low       | item   (sacm_pkg::in_item_t)
//  result    | done, one-cycle strobe     | result (sacm_pkg::result_t)
//  config    | psel, penable, pwrite      | paddr, pwdata / prdata
//
// For each item, the accept edge reads the set row from the set memory; the
// next cycle compares the ways in use and writes the row back. The
// result strobe shows in the cycle after, when the next item may be accepted.
// Reset clears the per-set init flags at once; there is no clearing pass.
// The receiver cannot stall; busy is high only during the compare cycle.
module set_assoc_cache_mru_model_unit #(
    parameter int MAX_SET_BITS = 8,
    parameter int WAYS         = 8,
    parameter int ADDR_WIDTH   = 64,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sacm_pkg::in_item_t item,
    output logic               done,
    output sacm_pkg::result_t  result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    sacm_pkg::cfg_t      cfg_reg;
    sacm_pkg::ctrl_cmd_t cmd;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_bits    <= sacm_pkg::SET_BITS_RST;
            cfg_reg.block_bits  <= sacm_pkg::BLOCK_BITS_RST;
            cfg_reg.ways_in_use <= sacm_pkg::WAYS_IN_USE_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                sacm_pkg::REG_SET_BITS:    cfg_reg.set_bits    <= pwdata[3:0];
                sacm_pkg::REG_BLOCK_BITS:  cfg_reg.block_bits  <= pwdata[5:0];
                sacm_pkg::REG_WAYS_IN_USE: cfg_reg.ways_in_use <= pwdata[3:0];
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            sacm_pkg::REG_SET_BITS:    prdata = 32'(cfg_reg.set_bits);
            sacm_pkg::REG_BLOCK_BITS:  prdata = 32'(cfg_reg.block_bits);
            sacm_pkg::REG_WAYS_IN_USE: prdata = 32'(cfg_reg.ways_in_use);
            default:                   prdata = '0;
        endcase
    end

    sacm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    sacm_datapath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .WAYS         (WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result)
    );

endmodule
